[rtl/core/seven_segment_scan_with_blink_core_defines.svh]
// ----------------------------------------------------------------------------
// Seven-segment scanner assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_WITH_BLINK_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_WITH_BLINK_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SSB_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define SSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// ssb_pkg
// Types, constants and the segment decode table of the seven-segment scanner.
// ----------------------------------------------------------------------------
package ssb_pkg;

	localparam logic [1:0] CFG_BLINK_ENABLE = 2'd0;
	localparam logic [1:0] CFG_BLINK_ON     = 2'd1;
	localparam logic [1:0] CFG_BLINK_OFF    = 2'd2;

	localparam logic       KIND_WRITE = 1'b0;
	localparam logic       KIND_TICK  = 1'b1;

	localparam logic [7:0]  DP_MASK        = 8'hfb;
	localparam logic [7:0]  BLANK_PATTERN  = 8'hff;
	localparam logic [7:0]  CHAR_DOT       = 8'h2e;
	localparam logic [7:0]  CHAR_NUL       = 8'h00;
	localparam logic [15:0] BLINK_RESET    = 16'd160;

	typedef logic [7:0] seg_t;

	// board-specific active-low segment table; unknown codes are blank
	function automatic seg_t decode_char(input logic [7:0] c);
		seg_t p;
		case (c)
			8'h30: p = 8'd5;
			8'h31: p = 8'd125;
			8'h32: p = 8'd70;
			8'h33: p = 8'd84;
			8'h34: p = 8'd60;
			8'h35: p = 8'd148;
			8'h36: p = 8'd132;
			8'h37: p = 8'd93;
			8'h38: p = 8'd4;
			8'h39: p = 8'd20;
			8'h53: p = 8'd148;
			8'h41: p = 8'd12;
			8'h50: p = 8'd14;
			8'h4c: p = 8'd167;
			8'h44: p = 8'd100;
			8'h4e: p = 8'd236;
			8'h48: p = 8'd44;
			8'h55: p = 8'd37;
			8'h4d: p = 8'd204;
			8'h49: p = 8'd175;
			8'h54: p = 8'd166;
			8'h45: p = 8'd134;
			8'h52: p = 8'd238;
			8'h4f: p = 8'd228;
			8'h46: p = 8'd142;
			8'h43: p = 8'd135;
			8'h2d: p = 8'd254;
			8'h27: p = 8'd127;
			8'h22: p = 8'd63;
			default: p = BLANK_PATTERN;
		endcase
		return p;
	endfunction

endpackage

[rtl/core/seven_segment_scan_with_blink_core.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_with_blink_core
// Multiplexed seven-segment scanner with a text store and a blink timer.
// ----------------------------------------------------------------------------
// A tick's result passes the input register, then the output register.
// Throughput: one transaction per cycle unless a tick waits on a stalled output;
// writes and ticks both pass the input register, and a tick's store read, decode and counter update are combinational.
// Reset: arst_n clears the text store, scan position and blink timer, and
// returns the config registers to their defaults.
`include "seven_segment_scan_with_blink_core_defines.svh"

module seven_segment_scan_with_blink_core #(
	parameter int TEXT_SLOTS  = 9,
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [3:0] slot, [11:4] char_code, [15:12] zero
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [7:0] segment_pattern, [9:8] digit_select,
	                              // [10] digit_on, [15:11] zero
);

	localparam int IW = $clog2(TEXT_SLOTS);
	localparam int PW = IW + 2;
	localparam int DW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic [7:0]    store_q [TEXT_SLOTS];
	logic [IW-1:0] read_idx_q;
	logic [DW-1:0] digit_pos_q;
	logic [15:0]   blink_cnt_q;
	logic          blink_phase_q;
	logic          blink_en_q;
	logic [15:0]   blink_on_q;
	logic [15:0]   blink_off_q;

	logic          valid_s1;
	logic          kind_s1;
	logic [3:0]    slot_s1;
	logic [7:0]    char_s1;

	logic          out_valid_q;
	ssb_pkg::seg_t pattern_q;
	logic [1:0]    select_q;
	logic          digit_on_q;

	logic          s1_go;
	logic          is_tick;
	logic [15:0]   cnt_inc;
	logic [15:0]   cnt_next;
	logic          phase_next;
	logic          shown;
	logic [PW-1:0] pos0;
	logic [PW-1:0] pos1;
	logic [PW-1:0] pos_adv;
	logic [7:0]    ch;
	logic [7:0]    nx;
	logic [7:0]    at_adv;
	logic          dot;
	ssb_pkg::seg_t pattern;
	logic [DW:0]   dp_inc;
	logic [DW-1:0] dp_wrap;
	logic          restart;
	logic [DW+1:0] dp_ext;

	assign is_tick  = kind_s1 == ssb_pkg::KIND_TICK;
	assign s1_go    = valid_s1 && (!is_tick || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_go;

	always_comb begin
		cnt_inc    = blink_cnt_q + 16'd1;
		cnt_next   = cnt_inc;
		phase_next = blink_phase_q;
		if (!blink_phase_q && cnt_inc > blink_on_q) begin
			cnt_next   = '0;
			phase_next = 1'b1;
		end else if (blink_phase_q && cnt_inc > blink_off_q) begin
			cnt_next   = '0;
			phase_next = 1'b0;
		end
		shown = !blink_en_q || !phase_next;

		pos0 = {2'b00, read_idx_q};
		pos1 = pos0 + PW'(1);
		ch   = store_q[read_idx_q];
		nx   = (pos1 < PW'(TEXT_SLOTS)) ? store_q[pos1[IW-1:0]] : ssb_pkg::CHAR_NUL;
		dot  = nx == ssb_pkg::CHAR_DOT;
		pattern = ssb_pkg::decode_char(ch) & (dot ? ssb_pkg::DP_MASK : ssb_pkg::BLANK_PATTERN);
		pos_adv = dot ? (pos1 + PW'(1)) : pos1;
		at_adv  = (pos_adv < PW'(TEXT_SLOTS)) ? store_q[pos_adv[IW-1:0]]
		                                      : ssb_pkg::CHAR_NUL;
		restart = (pos_adv >= PW'(TEXT_SLOTS)) || (at_adv == ssb_pkg::CHAR_NUL);

		dp_inc  = {1'b0, digit_pos_q} + (DW+1)'(1);
		dp_wrap = (dp_inc >= (DW+1)'(DIGIT_COUNT)) ? '0 : dp_inc[DW-1:0];
		dp_ext  = {2'b00, digit_pos_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_en_q  <= 1'b0;
			blink_on_q  <= ssb_pkg::BLINK_RESET;
			blink_off_q <= ssb_pkg::BLINK_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				ssb_pkg::CFG_BLINK_ENABLE: blink_en_q  <= cfg_data[0];
				ssb_pkg::CFG_BLINK_ON:     blink_on_q  <= cfg_data;
				ssb_pkg::CFG_BLINK_OFF:    blink_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			slot_s1 <= s_tdata[3:0];
			char_s1 <= s_tdata[11:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TEXT_SLOTS; i++) begin
				store_q[i] <= '0;
			end
			read_idx_q    <= '0;
			digit_pos_q   <= '0;
			blink_cnt_q   <= '0;
			blink_phase_q <= 1'b0;
		end else if (s1_go) begin
			if (!is_tick) begin
				if ({1'b0, slot_s1} < 5'(TEXT_SLOTS)) begin
					store_q[slot_s1[IW-1:0]] <= char_s1;
				end
			end else begin
				blink_cnt_q   <= cnt_next;
				blink_phase_q <= phase_next;
				if (shown && !restart) begin
					read_idx_q  <= pos_adv[IW-1:0];
					digit_pos_q <= dp_wrap;
				end else begin
					read_idx_q  <= '0;
					digit_pos_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_tick) begin
			pattern_q  <= shown ? pattern : ssb_pkg::BLANK_PATTERN;
			select_q   <= shown ? dp_ext[1:0] : 2'b00;
			digit_on_q <= shown;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, digit_on_q, select_q, pattern_q};

	`SSB_ASSERT_IMPLY(a_blank_when_off, out_valid_q && !digit_on_q,
		pattern_q == ssb_pkg::BLANK_PATTERN && select_q == 2'b00,
		"dark digit carries a non-blank result")
	`SSB_ASSERT_IMPLY(a_read_idx_range, 1'b1, {2'b00, read_idx_q} < PW'(TEXT_SLOTS),
		"read index beyond text store")
	`SSB_ASSERT_IMPLY(a_digit_range, 1'b1, {1'b0, digit_pos_q} < (DW+1)'(DIGIT_COUNT),
		"digit position beyond digit count")
	`SSB_ASSERT_NEXT(a_write_no_result,
		s1_go && !is_tick && out_valid_q && !m_tready, out_valid_q,
		"store write disturbed a pending result")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scanner testbench
// Drives character writes and scan ticks into the text store, runs the
// blink timer through several on/off settings, and checks every digit
// pattern against an in-bench model of the scanner, with bursty input
// traffic and a stalling output side.
// ----------------------------------------------------------------------------
module testbench;

	localparam int TEXT_SLOTS  = 9;
	localparam int DIGIT_COUNT = 4;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] pat;
		logic [1:0] dsel;
		logic       lit;
	} scan_res_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e  op;
		logic       kind;
		logic [3:0] slot;
		logic [7:0] code;
		logic [1:0] reg_idx;
		logic [15:0] reg_val;
		bit         typed;
		scan_res_t  res;
	} row_t;

	typedef enum logic [1:0] {RX_FREE, RX_THIRD, RX_HALF, RX_SPARSE} rx_mode_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;

	// model of the scanner
	logic [7:0]  text_mem [TEXT_SLOTS];
	int unsigned rd_idx;
	int unsigned digit_pos;
	logic [15:0] blink_cnt;
	bit          blank_phase;
	bit          reg_blink_en;
	logic [15:0] reg_on;
	logic [15:0] reg_off;

	scan_res_t pending_scans [$];
	row_t      script [$];

	int errors;
	int sent;
	int checked;
	int blanked;
	int burst_left;

	rx_mode_e rx_mode = RX_FREE;
	int       rx_span = 0;
	int       rx_phase = 0;

	seven_segment_scan_with_blink_core #(
		.TEXT_SLOTS (TEXT_SLOTS),
		.DIGIT_COUNT(DIGIT_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [7:0] glyph_for(input logic [7:0] c);
		case (c)
			"0": return 8'd5;
			"1": return 8'd125;
			"2": return 8'd70;
			"3": return 8'd84;
			"4": return 8'd60;
			"5": return 8'd148;
			"6": return 8'd132;
			"7": return 8'd93;
			"8": return 8'd4;
			"9": return 8'd20;
			"S": return 8'd148;
			"A": return 8'd12;
			"P": return 8'd14;
			"L": return 8'd167;
			"D": return 8'd100;
			"N": return 8'd236;
			"H": return 8'd44;
			"U": return 8'd37;
			"M": return 8'd204;
			"I": return 8'd175;
			"T": return 8'd166;
			"E": return 8'd134;
			"R": return 8'd238;
			"O": return 8'd228;
			"F": return 8'd142;
			"C": return 8'd135;
			"-": return 8'd254;
			"'": return 8'd127;
			8'h22: return 8'd63;
			default: return ssb_pkg::BLANK_PATTERN;
		endcase
	endfunction

	function automatic logic [7:0] text_at(input int unsigned pos);
		if (pos < TEXT_SLOTS)
			return text_mem[pos];
		return ssb_pkg::CHAR_NUL;
	endfunction

	function automatic bit predict_scan(input logic k, input logic [3:0] sl,
			input logic [7:0] cc, output scan_res_t r);
		r = '0;
		if (k == ssb_pkg::KIND_WRITE) begin
			if (sl < TEXT_SLOTS)
				text_mem[sl] = cc;
			return 1'b0;
		end
		blink_cnt = blink_cnt + 16'd1;
		if (!blank_phase && blink_cnt > reg_on) begin
			blink_cnt   = '0;
			blank_phase = 1'b1;
		end else if (blank_phase && blink_cnt > reg_off) begin
			blink_cnt   = '0;
			blank_phase = 1'b0;
		end
		if (!reg_blink_en || !blank_phase) begin
			r.pat = glyph_for(text_at(rd_idx));
			if (text_at(rd_idx + 1) == ssb_pkg::CHAR_DOT) begin
				r.pat = r.pat & ssb_pkg::DP_MASK;
				rd_idx++;
			end
			r.dsel = digit_pos[1:0];
			r.lit  = 1'b1;
			digit_pos = (digit_pos + 1 >= DIGIT_COUNT) ? 0 : digit_pos + 1;
			rd_idx++;
			if (rd_idx >= TEXT_SLOTS || text_at(rd_idx) == ssb_pkg::CHAR_NUL) begin
				rd_idx    = 0;
				digit_pos = 0;
			end
		end else begin
			rd_idx    = 0;
			digit_pos = 0;
			r.pat     = ssb_pkg::BLANK_PATTERN;
			r.dsel    = 2'd0;
			r.lit     = 1'b0;
			blanked++;
		end
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		if (errors < 40)
			$display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	// entered and left at a falling edge
	task automatic push_item(input logic k, input logic [3:0] sl, input logic [7:0] cc,
			input bit typed, input scan_res_t typed_res);
		scan_res_t r;
		bit        has_res;
		int        gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {4'b0000, cc, sl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		has_res = predict_scan(k, sl, cc, r);
		if (has_res)
			pending_scans.push_back(typed ? typed_res : r);
		sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_scans.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
		settle();
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			ssb_pkg::CFG_BLINK_ENABLE: reg_blink_en = val[0];
			ssb_pkg::CFG_BLINK_ON:     reg_on       = val;
			ssb_pkg::CFG_BLINK_OFF:    reg_off      = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	function automatic row_t step_row(input logic k, input logic [3:0] sl,
			input logic [7:0] cc);
		row_t t;
		t = '{op: ROW_ITEM, kind: k, slot: sl, code: cc, reg_idx: '0, reg_val: '0,
			typed: 1'b0, res: '0};
		return t;
	endfunction

	function automatic row_t known_row(input logic [7:0] pat, input logic [1:0] dsel,
			input logic lit);
		row_t t;
		t = step_row(ssb_pkg::KIND_TICK, 4'd0, 8'd0);
		t.typed = 1'b1;
		t.res   = '{pat: pat, dsel: dsel, lit: lit};
		return t;
	endfunction

	function automatic row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
		row_t t;
		t = step_row(ssb_pkg::KIND_WRITE, 4'd0, 8'd0);
		t.op      = ROW_REG;
		t.reg_idx = idx;
		t.reg_val = val;
		return t;
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
			rx_span <= $urandom_range(20, 80);
		end else begin
			rx_span <= rx_span - 1;
		end
		rx_phase <= (rx_phase == 2) ? 0 : rx_phase + 1;
		case (rx_mode)
			RX_FREE:   m_tready <= 1'b1;
			RX_THIRD:  m_tready <= (rx_phase != 0);
			RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
			default:   m_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin : result_check
		scan_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_scans.size() == 0) begin
				note_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = pending_scans.pop_front();
				checked++;
				if (m_tdata[7:0] !== want.pat)
					note_mismatch("segment_pattern", m_tdata[7:0], want.pat);
				if (m_tdata[9:8] !== want.dsel)
					note_mismatch("digit_select", m_tdata[9:8], want.dsel);
				if (m_tdata[10] !== want.lit)
					note_mismatch("digit_on", m_tdata[10], want.lit);
				if (m_tdata[15:11] !== 5'd0)
					note_mismatch("tdata padding", m_tdata[15:11], 0);
			end
		end
	end

	initial begin
		string      pool;
		logic       en;
		logic [15:0] on_val;
		logic [15:0] off_val;
		logic [7:0] cc;
		int         sel;
		row_t       t;

		pool = "0123456789SAPLDNHUMITERFOC-'..";
		for (int i = 0; i < TEXT_SLOTS; i++)
			text_mem[i] = ssb_pkg::CHAR_NUL;
		rd_idx       = 0;
		digit_pos    = 0;
		blink_cnt    = '0;
		blank_phase  = 1'b0;
		reg_blink_en = 1'b0;
		reg_on       = ssb_pkg::BLINK_RESET;
		reg_off      = ssb_pkg::BLINK_RESET;

		// empty store, dot folding, wrap at NUL, ignored slot, unknown code,
		// full store with a read past its end, then blink ticks, the first one blanked
		script.push_back(known_row(ssb_pkg::BLANK_PATTERN, 2'd0, 1'b1));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd0, "8"));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd1, ssb_pkg::CHAR_DOT));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd2, "-"));
		script.push_back(known_row(8'h00, 2'd0, 1'b1));
		script.push_back(known_row(8'd254, 2'd1, 1'b1));
		script.push_back(known_row(8'h00, 2'd0, 1'b1));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd15, "A"));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd3, 8'hff));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd4, "H"));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd5, "E"));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd6, "L"));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd7, "P"));
		script.push_back(step_row(ssb_pkg::KIND_WRITE, 4'd8, 8'h22));
		for (int i = 0; i < 8; i++)
			script.push_back(step_row(ssb_pkg::KIND_TICK, 4'd0, 8'd0));
		script.push_back(reg_row(ssb_pkg::CFG_BLINK_ENABLE, 16'd1));
		script.push_back(reg_row(ssb_pkg::CFG_BLINK_ON, 16'd0));
		script.push_back(reg_row(ssb_pkg::CFG_BLINK_OFF, 16'd0));
		script.push_back(reg_row(CFG_UNUSED, 16'hffff));
		script.push_back(known_row(ssb_pkg::BLANK_PATTERN, 2'd0, 1'b0));
		script.push_back(step_row(ssb_pkg::KIND_TICK, 4'd0, 8'd0));
		script.push_back(step_row(ssb_pkg::KIND_TICK, 4'd0, 8'd0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			t = script[i];
			if (t.op == ROW_REG)
				set_reg(t.reg_idx, t.reg_val);
			else
				push_item(t.kind, t.slot, t.code, t.typed, t.res);
		end

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					en = 1'b0;
					on_val  = ssb_pkg::BLINK_RESET;
					off_val = ssb_pkg::BLINK_RESET;
				end
				1: begin en = 1'b1; on_val = 16'd0; off_val = 16'd0; end
				2: begin
					en = 1'b1;
					on_val  = 16'($urandom_range(1, 8));
					off_val = 16'($urandom_range(1, 8));
				end
				3: begin en = 1'b1; on_val = 16'hffff; off_val = 16'd0; end
				4: begin
					en = 1'b1;
					on_val  = 16'($urandom_range(2, 12));
					off_val = 16'hffff;
				end
				default: begin
					en = 1'b0;
					on_val  = 16'($urandom_range(0, 3));
					off_val = 16'($urandom_range(0, 3));
				end
			endcase
			set_reg(ssb_pkg::CFG_BLINK_ENABLE, {15'd0, en});
			set_reg(ssb_pkg::CFG_BLINK_ON, on_val);
			set_reg(ssb_pkg::CFG_BLINK_OFF, off_val);
			if (ph == 2)
				set_reg(CFG_UNUSED, 16'hffff);
			repeat (100) begin
				sel = $urandom_range(0, 99);
				if (sel < 55) begin
					push_item(ssb_pkg::KIND_TICK, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)), 1'b0, '0);
				end else if (sel < 90) begin
					if ($urandom_range(0, 7) == 0)
						cc = ssb_pkg::CHAR_NUL;
					else
						cc = pool[$urandom_range(0, pool.len() - 1)];
					push_item(ssb_pkg::KIND_WRITE, 4'($urandom_range(0, TEXT_SLOTS - 1)),
						cc, 1'b0, '0);
				end else begin
					push_item(ssb_pkg::KIND_WRITE, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)), 1'b0, '0);
				end
			end
		end

		settle();
		$display("Sent %0d transactions over six blink settings; %0d scan results checked,",
			sent, checked);
		$display("%0d of them blanked, %0d mismatches.", blanked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
